[design/qvr_pkg.sv]
`default_nettype none
package qvr_pkg;

   localparam int QUO_W   = 24;
   localparam int NUM_STG = 6;
   localparam int DIV_STG = QUO_W;
   localparam int NSTG    = NUM_STG + DIV_STG + 1;
   localparam int LANES   = 3;

   typedef logic signed [15:0] qc_type;
   typedef logic signed [23:0] vec_type;
   typedef logic signed [31:0] sq_type;
   typedef logic signed [39:0] pp_type;
   typedef logic        [32:0] nrm_type;
   typedef logic signed [32:0] scl_type;
   typedef logic signed [41:0] dot_type;
   typedef logic signed [40:0] crs_type;
   typedef logic signed [56:0] sv_type;
   typedef logic signed [57:0] dv_type;
   typedef logic signed [56:0] wc_type;
   typedef logic signed [59:0] num_type;
   typedef logic        [57:0] mag_type;
   typedef logic        [55:0] den_type;
   typedef logic        [QUO_W-1:0] quo_type;

   localparam quo_type VEC_MAX  = 24'h7FFFFF;
   localparam quo_type VEC_MIN  = 24'h800000;
   localparam quo_type MIN_MAG  = 24'h800000;

   typedef struct packed {
      mag_type rem;
      quo_type quo;
      logic    neg;
      logic    ovf;
   } div_lane_type;

   typedef struct packed {
      div_lane_type [LANES-1:0] lane;
      den_type                  den;
      logic                     zero;
   } div_type;

endpackage
`default_nettype wire

[design/qvr_if.sv]
`default_nettype none
interface qvr_req_if;
   logic            valid;
   logic            ready;
   qvr_pkg::qc_type quat_w;
   qvr_pkg::qc_type quat_x;
   qvr_pkg::qc_type quat_y;
   qvr_pkg::qc_type quat_z;
   qvr_pkg::vec_type vec_x;
   qvr_pkg::vec_type vec_y;
   qvr_pkg::vec_type vec_z;

   modport source (output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                   input ready);
   modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                   output ready);
endinterface

interface qvr_rsp_if;
   logic             valid;
   logic             ready;
   qvr_pkg::vec_type out_x;
   qvr_pkg::vec_type out_y;
   qvr_pkg::vec_type out_z;
   logic             zero_norm;
   logic             saturated;

   modport source (output valid, out_x, out_y, out_z, zero_norm, saturated, input ready);
   modport sink   (input valid, out_x, out_y, out_z, zero_norm, saturated, output ready);
endinterface
`default_nettype wire

[design/quaternion_vector_rotate_unit.sv]
`default_nettype none
// Quaternion vector rotation unit.
// Input channel req carries a quaternion (Q2.14) and a vector (Q12.12);
// output channel rsp returns the rotated vector q*v*inv(q) with flags
// zero_norm (all quaternion parts zero, outputs zero) and saturated.
// Both channels transfer on valid and ready high at a rising clock edge.
// From the req transfer to rsp valid, six stages form the exact numerator
// and norm, 24 stages of a restoring divider produce one quotient bit
// each, one stage clips and registers the result. There is no feedback path.
// Throughput is one item per cycle unless rsp stalls with all slots full.
// Every stage carries a valid bit. When rsp stalls, a stage holds only if
// all stages after it are full, so empty slots close up and req stays
// ready while any slot in the pipeline is free.
// Synchronous reset clears all valid bits; data registers are not reset.
module quaternion_vector_rotate_unit (
   input  logic        clock,
   input  logic        reset,
   qvr_req_if.sink     req,
   qvr_rsp_if.source   rsp
);

   logic [qvr_pkg::NSTG-1:0] vld_ff, vld_in, adv;
   qvr_pkg::div_type         div_pipe [qvr_pkg::DIV_STG+1];
   qvr_pkg::div_lane_type    fin_lane;
   logic [qvr_pkg::LANES-1:0]                   big;
   logic [qvr_pkg::LANES-1:0][qvr_pkg::QUO_W-1:0] res_in, res_ff;
   logic                     zero_in, zero_ff, sat_in, sat_ff;

   always_comb begin
      for (int i = 0; i < qvr_pkg::NSTG; i++) begin
         adv[i] = rsp.ready || ((~vld_ff >> i) != '0);
      end
   end

   always_comb begin
      vld_in[0] = adv[0] ? req.valid : vld_ff[0];
      for (int i = 1; i < qvr_pkg::NSTG; i++) begin
         vld_in[i] = adv[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req.ready = adv[0];

   qvr_numer u_numer (
      .clock  (clock),
      .adv    (adv[qvr_pkg::NUM_STG-1:0]),
      .quat_w (req.quat_w),
      .quat_x (req.quat_x),
      .quat_y (req.quat_y),
      .quat_z (req.quat_z),
      .vec_x  (req.vec_x),
      .vec_y  (req.vec_y),
      .vec_z  (req.vec_z),
      .dout   (div_pipe[0])
   );

   for (genvar g = 0; g < qvr_pkg::DIV_STG; g++) begin : g_div
      qvr_div_stage u_div (
         .clock (clock),
         .en    (adv[qvr_pkg::NUM_STG+g]),
         .din   (div_pipe[g]),
         .dout  (div_pipe[g+1])
      );
   end

   // clip, restore sign, force zero output on a zero quaternion
   always_comb begin
      fin_lane = '0;
      zero_in  = div_pipe[qvr_pkg::DIV_STG].zero;
      for (int k = 0; k < qvr_pkg::LANES; k++) begin
         fin_lane = div_pipe[qvr_pkg::DIV_STG].lane[k];
         big[k]   = fin_lane.ovf || (fin_lane.neg ? (fin_lane.quo > qvr_pkg::MIN_MAG)
                                                  : fin_lane.quo[qvr_pkg::QUO_W-1]);
         if (zero_in) begin
            res_in[k] = '0;
         end else if (big[k]) begin
            res_in[k] = fin_lane.neg ? qvr_pkg::VEC_MIN : qvr_pkg::VEC_MAX;
         end else begin
            res_in[k] = fin_lane.neg ? -fin_lane.quo : fin_lane.quo;
         end
      end
      sat_in = !zero_in && (big != '0);
   end

   always_ff @(posedge clock) begin
      if (adv[qvr_pkg::NSTG-1]) begin
         res_ff  <= res_in;
         zero_ff <= zero_in;
         sat_ff  <= sat_in;
      end
   end

   assign rsp.valid     = vld_ff[qvr_pkg::NSTG-1];
   assign rsp.out_x     = res_ff[0];
   assign rsp.out_y     = res_ff[1];
   assign rsp.out_z     = res_ff[2];
   assign rsp.zero_norm = zero_ff;
   assign rsp.saturated = sat_ff;

endmodule
`default_nettype wire

[design/qvr_numer.sv]
`default_nettype none
module qvr_numer (
   input  logic                        clock,
   input  logic [qvr_pkg::NUM_STG-1:0] adv,
   input  qvr_pkg::qc_type             quat_w,
   input  qvr_pkg::qc_type             quat_x,
   input  qvr_pkg::qc_type             quat_y,
   input  qvr_pkg::qc_type             quat_z,
   input  qvr_pkg::vec_type            vec_x,
   input  qvr_pkg::vec_type            vec_y,
   input  qvr_pkg::vec_type            vec_z,
   output qvr_pkg::div_type            dout
);

   // stage 1: squares and element products
   qvr_pkg::sq_type  ww_ff, xx_ff, yy_ff, zz_ff;
   qvr_pkg::pp_type  pxa_ff, pyb_ff, pzc_ff, pyc_ff, pzb_ff, pza_ff, pxc_ff, pxb_ff, pya_ff;
   qvr_pkg::qc_type  w1_ff, x1_ff, y1_ff, z1_ff;
   qvr_pkg::vec_type a1_ff, b1_ff, c1_ff;

   // stage 2: norm, scale, dot and cross
   qvr_pkg::nrm_type n2_ff;
   qvr_pkg::scl_type s2_ff;
   qvr_pkg::dot_type d2_ff;
   qvr_pkg::crs_type cx2_ff, cy2_ff, cz2_ff;
   qvr_pkg::qc_type  w2_ff, x2_ff, y2_ff, z2_ff;
   qvr_pkg::vec_type a2_ff, b2_ff, c2_ff;

   // stage 3: term products
   qvr_pkg::sv_type  sa3_ff, sb3_ff, sc3_ff;
   qvr_pkg::dv_type  dx3_ff, dy3_ff, dz3_ff;
   qvr_pkg::wc_type  wx3_ff, wy3_ff, wz3_ff;
   qvr_pkg::nrm_type n3_ff;

   // stage 4: numerators
   qvr_pkg::num_type num4_ff [qvr_pkg::LANES];
   qvr_pkg::nrm_type n4_ff;

   // stage 5: magnitudes
   qvr_pkg::mag_type mag5_ff [qvr_pkg::LANES];
   logic [qvr_pkg::LANES-1:0] neg5_ff;
   qvr_pkg::nrm_type n5_ff;

   // stage 6: divider setup
   qvr_pkg::div_type d6_ff;
   qvr_pkg::div_type d6_in;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         ww_ff  <= qvr_pkg::sq_type'(quat_w) * qvr_pkg::sq_type'(quat_w);
         xx_ff  <= qvr_pkg::sq_type'(quat_x) * qvr_pkg::sq_type'(quat_x);
         yy_ff  <= qvr_pkg::sq_type'(quat_y) * qvr_pkg::sq_type'(quat_y);
         zz_ff  <= qvr_pkg::sq_type'(quat_z) * qvr_pkg::sq_type'(quat_z);
         pxa_ff <= qvr_pkg::pp_type'(quat_x) * qvr_pkg::pp_type'(vec_x);
         pyb_ff <= qvr_pkg::pp_type'(quat_y) * qvr_pkg::pp_type'(vec_y);
         pzc_ff <= qvr_pkg::pp_type'(quat_z) * qvr_pkg::pp_type'(vec_z);
         pyc_ff <= qvr_pkg::pp_type'(quat_y) * qvr_pkg::pp_type'(vec_z);
         pzb_ff <= qvr_pkg::pp_type'(quat_z) * qvr_pkg::pp_type'(vec_y);
         pza_ff <= qvr_pkg::pp_type'(quat_z) * qvr_pkg::pp_type'(vec_x);
         pxc_ff <= qvr_pkg::pp_type'(quat_x) * qvr_pkg::pp_type'(vec_z);
         pxb_ff <= qvr_pkg::pp_type'(quat_x) * qvr_pkg::pp_type'(vec_y);
         pya_ff <= qvr_pkg::pp_type'(quat_y) * qvr_pkg::pp_type'(vec_x);
         w1_ff  <= quat_w;
         x1_ff  <= quat_x;
         y1_ff  <= quat_y;
         z1_ff  <= quat_z;
         a1_ff  <= vec_x;
         b1_ff  <= vec_y;
         c1_ff  <= vec_z;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         n2_ff  <= qvr_pkg::nrm_type'(ww_ff) + qvr_pkg::nrm_type'(xx_ff)
                 + qvr_pkg::nrm_type'(yy_ff) + qvr_pkg::nrm_type'(zz_ff);
         s2_ff  <= qvr_pkg::scl_type'(ww_ff) - qvr_pkg::scl_type'(xx_ff)
                 - qvr_pkg::scl_type'(yy_ff) - qvr_pkg::scl_type'(zz_ff);
         d2_ff  <= qvr_pkg::dot_type'(pxa_ff) + qvr_pkg::dot_type'(pyb_ff)
                 + qvr_pkg::dot_type'(pzc_ff);
         cx2_ff <= qvr_pkg::crs_type'(pyc_ff) - qvr_pkg::crs_type'(pzb_ff);
         cy2_ff <= qvr_pkg::crs_type'(pza_ff) - qvr_pkg::crs_type'(pxc_ff);
         cz2_ff <= qvr_pkg::crs_type'(pxb_ff) - qvr_pkg::crs_type'(pya_ff);
         w2_ff  <= w1_ff;
         x2_ff  <= x1_ff;
         y2_ff  <= y1_ff;
         z2_ff  <= z1_ff;
         a2_ff  <= a1_ff;
         b2_ff  <= b1_ff;
         c2_ff  <= c1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         sa3_ff <= qvr_pkg::sv_type'(s2_ff) * qvr_pkg::sv_type'(a2_ff);
         sb3_ff <= qvr_pkg::sv_type'(s2_ff) * qvr_pkg::sv_type'(b2_ff);
         sc3_ff <= qvr_pkg::sv_type'(s2_ff) * qvr_pkg::sv_type'(c2_ff);
         dx3_ff <= qvr_pkg::dv_type'(d2_ff) * qvr_pkg::dv_type'(x2_ff);
         dy3_ff <= qvr_pkg::dv_type'(d2_ff) * qvr_pkg::dv_type'(y2_ff);
         dz3_ff <= qvr_pkg::dv_type'(d2_ff) * qvr_pkg::dv_type'(z2_ff);
         wx3_ff <= qvr_pkg::wc_type'(w2_ff) * qvr_pkg::wc_type'(cx2_ff);
         wy3_ff <= qvr_pkg::wc_type'(w2_ff) * qvr_pkg::wc_type'(cy2_ff);
         wz3_ff <= qvr_pkg::wc_type'(w2_ff) * qvr_pkg::wc_type'(cz2_ff);
         n3_ff  <= n2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         num4_ff[0] <= qvr_pkg::num_type'(sa3_ff) + (qvr_pkg::num_type'(dx3_ff) <<< 1)
                     + (qvr_pkg::num_type'(wx3_ff) <<< 1);
         num4_ff[1] <= qvr_pkg::num_type'(sb3_ff) + (qvr_pkg::num_type'(dy3_ff) <<< 1)
                     + (qvr_pkg::num_type'(wy3_ff) <<< 1);
         num4_ff[2] <= qvr_pkg::num_type'(sc3_ff) + (qvr_pkg::num_type'(dz3_ff) <<< 1)
                     + (qvr_pkg::num_type'(wz3_ff) <<< 1);
         n4_ff      <= n3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         for (int k = 0; k < qvr_pkg::LANES; k++) begin
            neg5_ff[k] <= num4_ff[k][59];
            mag5_ff[k] <= qvr_pkg::mag_type'(num4_ff[k][59] ? -num4_ff[k] : num4_ff[k]);
         end
         n5_ff <= n4_ff;
      end
   end

   always_comb begin
      d6_in.den  = qvr_pkg::den_type'(n5_ff) << (qvr_pkg::QUO_W - 1);
      d6_in.zero = (n5_ff == '0);
      for (int k = 0; k < qvr_pkg::LANES; k++) begin
         d6_in.lane[k].rem = mag5_ff[k];
         d6_in.lane[k].quo = '0;
         d6_in.lane[k].neg = neg5_ff[k];
         d6_in.lane[k].ovf = (mag5_ff[k][57:qvr_pkg::QUO_W] >= {1'b0, n5_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         d6_ff <= d6_in;
      end
   end

   assign dout = d6_ff;

endmodule
`default_nettype wire

[design/qvr_div_stage.sv]
`default_nettype none
module qvr_div_stage (
   input  logic             clock,
   input  logic             en,
   input  qvr_pkg::div_type din,
   output qvr_pkg::div_type dout
);

   qvr_pkg::div_type stg_ff;
   qvr_pkg::div_type stg_in;
   logic [qvr_pkg::LANES-1:0] ge;

   // restore step: one quotient bit per lane, divisor moves down one place
   always_comb begin
      stg_in      = din;
      stg_in.den  = din.den >> 1;
      for (int k = 0; k < qvr_pkg::LANES; k++) begin
         ge[k] = (din.lane[k].rem >= qvr_pkg::mag_type'(din.den));
         stg_in.lane[k].rem = ge[k] ? din.lane[k].rem - qvr_pkg::mag_type'(din.den)
                                    : din.lane[k].rem;
         stg_in.lane[k].quo = {din.lane[k].quo[qvr_pkg::QUO_W-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stg_ff <= stg_in;
      end
   end

   assign dout = stg_ff;

endmodule
`default_nettype wire

[design/qvr_checker.sv]
`default_nettype none
module qvr_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  qvr_pkg::vec_type rsp_out_x,
   input  qvr_pkg::vec_type rsp_out_y,
   input  qvr_pkg::vec_type rsp_out_z,
   input  logic             rsp_zero_norm,
   input  logic             rsp_saturated
);

   a_rst_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped without transfer");

   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_norm |->
         rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0 && !rsp_saturated)
      else $error("zero quaternion with nonzero result");

   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_out_x == 24'sh7FFFFF || rsp_out_x == -24'sh800000 ||
         rsp_out_y == 24'sh7FFFFF || rsp_out_y == -24'sh800000 ||
         rsp_out_z == 24'sh7FFFFF || rsp_out_z == -24'sh800000)
      else $error("saturated flag without a clipped component");

endmodule

bind quaternion_vector_rotate_unit qvr_checker u_qvr_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_out_x     (rsp.out_x),
   .rsp_out_y     (rsp.out_y),
   .rsp_out_z     (rsp.out_z),
   .rsp_zero_norm (rsp.zero_norm),
   .rsp_saturated (rsp.saturated)
);
`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
module testbench;

   typedef struct {
      qvr_pkg::qc_type  w, x, y, z;
      qvr_pkg::vec_type a, b, c;
   } rotation_req_type;

   typedef struct {
      qvr_pkg::vec_type rx, ry, rz;
      logic             zero;
      logic             clip;
   } rotation_rsp_type;

   logic clock;
   logic reset;

   qvr_req_if req_bus ();
   qvr_rsp_if rsp_bus ();

   quaternion_vector_rotate_unit DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   rotation_req_type pending_rotations[$];
   rotation_rsp_type expected_vectors[$];
   int               errors;
   int               sent_count;
   int               checked_count;
   int               zero_seen;
   int               clip_seen;
   int               burst_left;
   int               gap_left;
   int               stall_mode;
   int               mode_left;
   int               stall_phase;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic longint clip_quotient(longint num, longint den, ref logic clip);
      longint q;
      q = num / den;
      if (q > 64'sd8388607) begin
         clip = 1'b1;
         return 64'sd8388607;
      end
      if (q < -64'sd8388608) begin
         clip = 1'b1;
         return -64'sd8388608;
      end
      return q;
   endfunction

   function automatic rotation_rsp_type rotate_vector(rotation_req_type r);
      rotation_rsp_type o;
      longint w, x, y, z, a, b, c;
      longint uu, n, s, d, cx, cy, cz;
      logic   clip;
      w = r.w; x = r.x; y = r.y; z = r.z;
      a = r.a; b = r.b; c = r.c;
      uu = x * x + y * y + z * z;
      n = w * w + uu;
      clip = 1'b0;
      o.rx = '0; o.ry = '0; o.rz = '0;
      o.zero = (n == 0);
      if (n != 0) begin
         s = w * w - uu;
         d = x * a + y * b + z * c;
         cx = y * c - z * b;
         cy = z * a - x * c;
         cz = x * b - y * a;
         o.rx = qvr_pkg::vec_type'(clip_quotient(s * a + 2 * d * x + 2 * w * cx, n, clip));
         o.ry = qvr_pkg::vec_type'(clip_quotient(s * b + 2 * d * y + 2 * w * cy, n, clip));
         o.rz = qvr_pkg::vec_type'(clip_quotient(s * c + 2 * d * z + 2 * w * cz, n, clip));
      end
      o.clip = clip;
      return o;
   endfunction

   function automatic rotation_rsp_type rotate_req_bus();
      rotation_req_type r;
      r.w = req_bus.quat_w; r.x = req_bus.quat_x;
      r.y = req_bus.quat_y; r.z = req_bus.quat_z;
      r.a = req_bus.vec_x;  r.b = req_bus.vec_y; r.c = req_bus.vec_z;
      return rotate_vector(r);
   endfunction

   task automatic add_rotation(int w, int x, int y, int z, int a, int b, int c);
      rotation_req_type r;
      r.w = qvr_pkg::qc_type'(w); r.x = qvr_pkg::qc_type'(x);
      r.y = qvr_pkg::qc_type'(y); r.z = qvr_pkg::qc_type'(z);
      r.a = qvr_pkg::vec_type'(a); r.b = qvr_pkg::vec_type'(b);
      r.c = qvr_pkg::vec_type'(c);
      pending_rotations.push_back(r);
   endtask

   function automatic int rand_quat_part(int kind);
      case (kind)
         0: return $urandom_range(0, 65535) - 32768;
         1: return $urandom_range(0, 32768) - 16384;
         2: return $urandom_range(0, 255) - 128;
         default: return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      endcase
   endfunction

   function automatic int rand_vec_part(int kind);
      case (kind)
         0: return $urandom_range(0, 24'hFFFFFF) - 8388608;
         1: return $urandom_range(0, 65535) - 32768;
         default: return ($urandom_range(0, 1) != 0) ? 8388607 : -8388608;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = $urandom_range(1, 30);
         gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_vectors.push_back(rotate_req_bus());
            sent_count++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (pending_rotations.size() > 0) begin
               rotation_req_type r;
               r = pending_rotations.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.quat_w <= r.w;
               req_bus.quat_x <= r.x;
               req_bus.quat_y <= r.y;
               req_bus.quat_z <= r.z;
               req_bus.vec_x <= r.a;
               req_bus.vec_y <= r.b;
               req_bus.vec_z <= r.c;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_mode = 0;
         mode_left = 100;
         stall_phase = 0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(40, 300);
         end else begin
            mode_left--;
         end
         stall_phase++;
         case (stall_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 1) != 0);
            2: rsp_bus.ready <= (stall_phase % 4 == 0);
            default: rsp_bus.ready <= (stall_phase % 64 >= 40);
         endcase
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_vectors.size() == 0) begin
            $error("unexpected transfer: out_x %0d", rsp_bus.out_x);
            errors++;
         end else begin
            rotation_rsp_type e;
            e = expected_vectors.pop_front();
            checked_count++;
            if (rsp_bus.zero_norm) zero_seen++;
            if (rsp_bus.saturated) clip_seen++;
            if (rsp_bus.out_x !== e.rx) begin
               $error("out_x expected %0d actual %0d", e.rx, rsp_bus.out_x);
               errors++;
            end
            if (rsp_bus.out_y !== e.ry) begin
               $error("out_y expected %0d actual %0d", e.ry, rsp_bus.out_y);
               errors++;
            end
            if (rsp_bus.out_z !== e.rz) begin
               $error("out_z expected %0d actual %0d", e.rz, rsp_bus.out_z);
               errors++;
            end
            if (rsp_bus.zero_norm !== e.zero) begin
               $error("zero_norm expected %0b actual %0b", e.zero, rsp_bus.zero_norm);
               errors++;
            end
            if (rsp_bus.saturated !== e.clip) begin
               $error("saturated expected %0b actual %0b", e.clip, rsp_bus.saturated);
               errors++;
            end
         end
      end
   end

   initial begin
      int qk;
      int vk;
      errors = 0;
      sent_count = 0;
      checked_count = 0;
      zero_seen = 0;
      clip_seen = 0;
      req_bus.valid = 1'b0;
      req_bus.quat_w = '0;
      req_bus.quat_x = '0;
      req_bus.quat_y = '0;
      req_bus.quat_z = '0;
      req_bus.vec_x = '0;
      req_bus.vec_y = '0;
      req_bus.vec_z = '0;
      rsp_bus.ready = 1'b0;
      reset = 1'b1;

      add_rotation(0, 0, 0, 0, 12345, -678, 4096);
      add_rotation(0, 0, 0, 0, 8388607, -8388608, 8388607);
      add_rotation(16384, 0, 0, 0, 4096, 8192, -12288);
      add_rotation(16384, 0, 0, 0, 8388607, -8388608, 0);
      add_rotation(-32768, 0, 0, 0, -8388608, 8388607, -8388608);
      add_rotation(11585, 0, 0, 11585, 4096, 0, 0);
      add_rotation(0, 16384, 0, 0, 4096, 8192, 12288);
      add_rotation(0, 0, 32767, 0, 8388607, 8388607, 8388607);
      add_rotation(0, 0, 0, -32768, 100, -200, 300);
      add_rotation(15137, 0, 0, 6270, 8388607, 8388607, 8388607);
      add_rotation(15137, 0, 0, 6270, -8388608, -8388608, -8388608);
      add_rotation(-32768, -32768, -32768, -32768, 8388607, -8388608, 8388607);
      add_rotation(32767, 32767, 32767, 32767, -8388608, -8388608, 8388607);
      add_rotation(1, 0, 0, 0, 1, -1, 1);
      add_rotation(0, 0, 0, 1, -1, 0, 0);
      add_rotation(1, 1, 1, 1, 8388607, 0, -8388608);
      add_rotation(200, -300, 32767, -32768, 8388607, 8388607, 8388607);
      add_rotation(8192, 8192, 8192, 8192, 4096, 4096, 4096);
      add_rotation(0, 0, 0, 0, 0, 0, 0);

      repeat (1600) begin
         qk = $urandom_range(0, 9);
         vk = $urandom_range(0, 9);
         qk = (qk < 5) ? 0 : (qk < 8) ? 1 : (qk < 9) ? 2 : 3;
         vk = (vk < 6) ? 0 : (vk < 9) ? 1 : 2;
         if ($urandom_range(0, 49) == 0)
            add_rotation(0, 0, 0, 0, rand_vec_part(vk), rand_vec_part(vk), rand_vec_part(vk));
         else
            add_rotation(rand_quat_part(qk), rand_quat_part(qk), rand_quat_part(qk),
                         rand_quat_part(qk), rand_vec_part(vk), rand_vec_part(vk),
                         rand_vec_part(vk));
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (pending_rotations.size() == 0);
      @(posedge clock);
      while (req_bus.valid) @(posedge clock);
      while (expected_vectors.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("sent %0d rotations, checked %0d results", sent_count, checked_count);
      $display("zero quaternions %0d, clipped results %0d", zero_seen, clip_seen);
      if (errors == 0 && expected_vectors.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

endmodule
